FILE: rtl/poblend_pkg.sv
// Shared types, constants and arithmetic helpers for the premultiplied overlay blend.
package poblend_pkg;

    localparam logic [1:0] FMT_YUY2 = 2'd0;
    localparam logic [1:0] FMT_NV12 = 2'd1;
    localparam logic [1:0] FMT_BGRA = 2'd2;

    localparam logic REG_PIXEL_FORMAT   = 1'b0;
    localparam logic REG_FOUR_BYTE      = 1'b1;

    localparam int RECIP_SHIFT = 28;
    localparam logic [18:0] RECIP_1000 = 19'd268436;

    localparam logic [7:0] LEVEL_LUMA   = 8'd16;
    localparam logic [7:0] LEVEL_CHROMA = 8'd128;
    localparam logic [7:0] LEVEL_BGRA   = 8'd0;
    localparam logic [15:0] ROUND_BIAS  = 16'd127;

    localparam logic [3:0] MASK_A     = 4'b0001;
    localparam logic [3:0] MASK_BC    = 4'b0110;
    localparam logic [3:0] MASK_ABC   = 4'b0111;
    localparam logic [3:0] MASK_ALPHA = 4'b1000;
    localparam logic [3:0] MASK_NONE  = 4'b0000;

    typedef struct packed {
        logic [1:0] pixel_format;
        logic       four_byte_pixel;
    } t_cfg;

    typedef struct packed {
        logic [7:0] ov_blue;
        logic [7:0] ov_green;
        logic [7:0] ov_red;
        logic [7:0] ov_alpha;
        logic [7:0] frame_byte_a;
        logic [7:0] frame_byte_b;
        logic [7:0] frame_byte_c;
        logic       column_even;
        logic       row_even;
    } t_item;

    typedef struct packed {
        logic [7:0] new_byte_a;
        logic [7:0] new_byte_b;
        logic [7:0] new_byte_c;
        logic [3:0] write_mask;
    } t_result;

    // Low byte of an unsigned value below 2^18 divided by 1000, by reciprocal multiply.
    function automatic logic [7:0] div1000_lo(input logic [17:0] mag);
        logic [36:0] prod;
        logic [8:0]  quot;
        prod = {19'd0, mag} * {18'd0, RECIP_1000};
        quot = prod[RECIP_SHIFT +: 9];
        return quot[7:0];
    endfunction

    // Low byte of a signed value divided by 1000, truncating toward zero.
    function automatic logic [7:0] sdiv1000_lo(input logic signed [18:0] val);
        logic [18:0] mag_full;
        logic [7:0]  q;
        mag_full = val[18] ? (~val + 19'd1) : val;
        q = div1000_lo(mag_full[17:0]);
        return val[18] ? (~q + 8'd1) : q;
    endfunction

    // Rounded blend of a frame byte toward a level, weighted by alpha.
    function automatic logic [7:0] toward(input logic [7:0] level, input logic [7:0] alpha,
                                          input logic [7:0] frame);
        logic [15:0] sum;
        sum = {8'd0, level} * {8'd0, alpha}
            + {8'd0, frame} * {8'd0, 8'd255 - alpha}
            + ROUND_BIAS;
        return sum[15:8];
    endfunction

endpackage

FILE: rtl/poblend_cfg.sv
// Configuration registers for pixel format and pixel size.
module poblend_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [1:0]          i_cfg_data,
    output poblend_pkg::t_cfg   o_cfg
);

    poblend_pkg::t_cfg r_cfg;
    poblend_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                poblend_pkg::REG_PIXEL_FORMAT: n_cfg.pixel_format    = i_cfg_data;
                poblend_pkg::REG_FOUR_BYTE:    n_cfg.four_byte_pixel = i_cfg_data[0];
                default:                       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format    <= poblend_pkg::FMT_YUY2;
            r_cfg.four_byte_pixel <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/poblend_math.sv
// Blend datapath: color conversion, alpha blend and write mask for one pixel.
module poblend_math (
    input  poblend_pkg::t_item   i_item,
    input  poblend_pkg::t_cfg    i_cfg,
    output poblend_pkg::t_result o_result
);

    logic [17:0]        y_sum;
    logic signed [18:0] u_sum;
    logic signed [18:0] v_sum;
    logic [7:0]         y_off;
    logic [7:0]         u_off;
    logic [7:0]         v_off;
    logic               is_yuv;
    logic               chroma_en;

    always_comb begin
        y_sum = 18'd183 * {10'd0, i_item.ov_red}
              + 18'd614 * {10'd0, i_item.ov_green}
              + 18'd62  * {10'd0, i_item.ov_blue};
        u_sum = 19'sd439 * $signed({11'd0, i_item.ov_blue})
              - 19'sd101 * $signed({11'd0, i_item.ov_red})
              - 19'sd339 * $signed({11'd0, i_item.ov_green});
        v_sum = 19'sd439 * $signed({11'd0, i_item.ov_red})
              - 19'sd399 * $signed({11'd0, i_item.ov_green})
              - 19'sd40  * $signed({11'd0, i_item.ov_blue});
        y_off = poblend_pkg::div1000_lo(y_sum);
        u_off = poblend_pkg::sdiv1000_lo(u_sum);
        v_off = poblend_pkg::sdiv1000_lo(v_sum);

        is_yuv    = (i_cfg.pixel_format == poblend_pkg::FMT_YUY2) ||
                    (i_cfg.pixel_format == poblend_pkg::FMT_NV12);
        chroma_en = i_item.column_even &&
                    ((i_cfg.pixel_format == poblend_pkg::FMT_YUY2) || i_item.row_even);

        o_result.new_byte_a = i_item.frame_byte_a;
        o_result.new_byte_b = i_item.frame_byte_b;
        o_result.new_byte_c = i_item.frame_byte_c;
        o_result.write_mask = poblend_pkg::MASK_NONE;

        if (i_item.ov_alpha != 8'd0) begin
            if (is_yuv) begin
                o_result.new_byte_a = y_off + poblend_pkg::toward(poblend_pkg::LEVEL_LUMA,
                                      i_item.ov_alpha, i_item.frame_byte_a);
                o_result.write_mask = poblend_pkg::MASK_A;
                if (chroma_en) begin
                    o_result.new_byte_b = u_off + poblend_pkg::toward(
                        poblend_pkg::LEVEL_CHROMA, i_item.ov_alpha, i_item.frame_byte_b);
                    o_result.new_byte_c = v_off + poblend_pkg::toward(
                        poblend_pkg::LEVEL_CHROMA, i_item.ov_alpha, i_item.frame_byte_c);
                    o_result.write_mask = poblend_pkg::MASK_A | poblend_pkg::MASK_BC;
                end
            end else if (i_cfg.pixel_format == poblend_pkg::FMT_BGRA) begin
                o_result.new_byte_a = i_item.ov_blue + poblend_pkg::toward(
                    poblend_pkg::LEVEL_BGRA, i_item.ov_alpha, i_item.frame_byte_a);
                o_result.new_byte_b = i_item.ov_green + poblend_pkg::toward(
                    poblend_pkg::LEVEL_BGRA, i_item.ov_alpha, i_item.frame_byte_b);
                o_result.new_byte_c = i_item.ov_red + poblend_pkg::toward(
                    poblend_pkg::LEVEL_BGRA, i_item.ov_alpha, i_item.frame_byte_c);
                o_result.write_mask = i_cfg.four_byte_pixel
                                    ? (poblend_pkg::MASK_ABC | poblend_pkg::MASK_ALPHA)
                                    : poblend_pkg::MASK_ABC;
            end
        end
    end

endmodule

FILE: rtl/premultiplied_overlay_blend_yuv_bgra.sv
// Top level of the premultiplied overlay blend with input and result registers.
//
// Usage: each input transaction carries one premultiplied BGRA overlay pixel,
// the three frame bytes it covers and the pixel's column and row parity. Each
// one yields exactly one result transaction with the new frame bytes and a
// four-bit write mask. Both channels use valid and stall; a transaction
// completes at a clock edge with valid high and stall low.
// An input transaction is captured in the input register; the blend logic then
// feeds the result register, from which the result transaction is taken.
// Throughput is one transaction per cycle while the receiver does not stall;
// the rate is set by the single blend stage between the two registers.
// When the receiver stalls, the result register holds its data and the input
// register keeps taking a transaction until it is full, so one pixel waits in
// each register. Stall toward the sender rises only when both are full.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data while
// no transaction is in flight. A synchronous active-low reset empties both
// registers and sets the format to YUY2 with four-byte pixels.
module premultiplied_overlay_blend_yuv_bgra (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_ov_blue,
    input  logic [7:0] i_ov_green,
    input  logic [7:0] i_ov_red,
    input  logic [7:0] i_ov_alpha,
    input  logic [7:0] i_frame_byte_a,
    input  logic [7:0] i_frame_byte_b,
    input  logic [7:0] i_frame_byte_c,
    input  logic       i_column_even,
    input  logic       i_row_even,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_new_byte_a,
    output logic [7:0] o_new_byte_b,
    output logic [7:0] o_new_byte_c,
    output logic [3:0] o_write_mask
);

    poblend_pkg::t_cfg    cfg;
    poblend_pkg::t_item   r_item;
    poblend_pkg::t_result blend_result;
    poblend_pkg::t_result r_result;
    logic                 r_item_valid;
    logic                 r_result_valid;
    logic                 result_load;
    logic                 item_load;

    poblend_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    poblend_math u_math (
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (blend_result)
    );

    assign result_load = !r_result_valid || !i_out_stall;
    assign item_load   = !r_item_valid || result_load;
    assign o_in_stall  = !item_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid   <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            if (item_load) begin
                r_item_valid <= i_in_valid;
            end
            if (result_load) begin
                r_result_valid <= r_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_load && i_in_valid) begin
            r_item.ov_blue      <= i_ov_blue;
            r_item.ov_green     <= i_ov_green;
            r_item.ov_red       <= i_ov_red;
            r_item.ov_alpha     <= i_ov_alpha;
            r_item.frame_byte_a <= i_frame_byte_a;
            r_item.frame_byte_b <= i_frame_byte_b;
            r_item.frame_byte_c <= i_frame_byte_c;
            r_item.column_even  <= i_column_even;
            r_item.row_even     <= i_row_even;
        end
        if (result_load && r_item_valid) begin
            r_result <= blend_result;
        end
    end

    assign o_out_valid  = r_result_valid;
    assign o_new_byte_a = r_result.new_byte_a;
    assign o_new_byte_b = r_result.new_byte_b;
    assign o_new_byte_c = r_result.new_byte_c;
    assign o_write_mask = r_result.write_mask;

endmodule
